>>> hdl/deq_pkg.sv
// Package for the double-ended queue core: request and status codes,
// entry layout and controller/datapath interface structs.
// No dependencies.
package deq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned InDataW = ((ValueW + 1 + 7) / 8) * 8;

  localparam logic [FuncW-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FuncW-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FuncW-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FuncW-1:0] FUNC_PEEK_FRONT = 3'd4;
  localparam logic [FuncW-1:0] FUNC_PEEK_BACK  = 3'd5;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic              tag;
    logic [ValueW-1:0] value;
  } deq_entry_t;

  typedef struct packed {
    logic latch_in;
    logic access;
    logic load_out;
  } deq_cmd_t;

  typedef struct packed {
    logic out_busy;
  } deq_stat_t;

endpackage

>>> hdl/deq_ctrl.sv
// Controller for the double-ended queue core: sequences accept, ring
// access and response load. Depends on deq_pkg.
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              m_ready_i,
  input  deq_pkg::deq_stat_t stat_i,
  output logic              s_ready_o,
  output deq_pkg::deq_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACCESS = 2'd1;
  localparam logic [1:0] ST_RESP   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_free;

  assign out_free = !stat_i.out_busy || m_ready_i;

  always_comb begin
    state_d        = state_q;
    s_ready_o      = 1'b0;
    cmd_o.latch_in = 1'b0;
    cmd_o.access   = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/deq_datapath.sv
// Datapath for the double-ended queue core: entry ring memory, head and
// count registers, request latch and output register. Depends on deq_pkg.
module deq_datapath #(
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned CW    = $clog2(DEPTH + 1),
  localparam int unsigned OUT_W = ((deq_pkg::ValueW + 1 + CW + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  deq_pkg::deq_cmd_t               cmd_i,
  output deq_pkg::deq_stat_t              stat_o,
  input  logic [deq_pkg::FuncW-1:0]       func_i,
  input  logic signed [deq_pkg::ValueW-1:0] value_i,
  input  logic                            tag_i,
  input  logic                            m_ready_i,
  output logic                            m_valid_o,
  output logic [OUT_W-1:0]                m_data_o,
  output logic [deq_pkg::StatW-1:0]       m_user_o
);

  localparam logic [AW:0]   DepthW  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

  deq_pkg::deq_entry_t mem_q [DEPTH];
  deq_pkg::deq_entry_t rd_q;

  logic [deq_pkg::FuncW-1:0]  func_q;
  logic [deq_pkg::ValueW-1:0] value_q;
  logic                       tag_q;
  logic [deq_pkg::StatW-1:0]  status_q, status_d;
  logic                       rd_ok_q, rd_ok_d;
  logic [AW-1:0]              head_q, head_d;
  logic [CW-1:0]              count_q, count_d;
  logic                       m_valid_q, m_valid_d;
  logic [OUT_W-1:0]           m_data_q, m_data_d;
  logic [deq_pkg::StatW-1:0]  m_user_q;

  logic          full, empty, push_op;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] offset, back_pos, head_inc, head_dec, addr;
  logic [AW:0]   back_sum;
  logic          we, re;

  always_comb begin
    full     = (count_q == DepthC);
    empty    = (count_q == '0);
    count_m1 = count_q - 1'b1;
    push_op  = (func_q == deq_pkg::FUNC_PUSH_BACK);
    offset   = push_op ? count_q[AW-1:0] : count_m1[AW-1:0];
    back_sum = {1'b0, head_q} + {1'b0, offset};
    back_pos = (back_sum >= DepthW) ? AW'(back_sum - DepthW) : back_sum[AW-1:0];
    head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;
    head_dec = (head_q == '0) ? LastIdx : head_q - 1'b1;

    head_d   = head_q;
    count_d  = count_q;
    status_d = deq_pkg::STAT_OK;
    rd_ok_d  = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    addr     = head_q;
    case (func_q) inside
      deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
        if (full) begin
          status_d = deq_pkg::STAT_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
          if (push_op) begin
            addr = back_pos;
          end else begin
            addr   = head_dec;
            head_d = head_dec;
          end
        end
      end
      deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_PEEK_FRONT: begin
        if (empty) begin
          status_d = deq_pkg::STAT_EMPTY;
        end else begin
          re      = 1'b1;
          rd_ok_d = 1'b1;
          if (func_q == deq_pkg::FUNC_POP_FRONT) begin
            head_d  = head_inc;
            count_d = count_m1;
          end
        end
      end
      deq_pkg::FUNC_POP_BACK, deq_pkg::FUNC_PEEK_BACK: begin
        if (empty) begin
          status_d = deq_pkg::STAT_EMPTY;
        end else begin
          re      = 1'b1;
          rd_ok_d = 1'b1;
          addr    = back_pos;
          if (func_q == deq_pkg::FUNC_POP_BACK) begin
            count_d = count_m1;
          end
        end
      end
      default: begin
        status_d = deq_pkg::STAT_OK;
      end
    endcase
  end

  // ring memory: one write or one registered read per access cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.access && we) begin
      mem_q[addr] <= '{tag: tag_q, value: value_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.access && re) begin
      rd_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q  <= func_i;
      value_q <= value_i;
      tag_q   <= tag_i;
    end
    if (cmd_i.access) begin
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
    end
    if (cmd_i.load_out) begin
      m_data_q <= m_data_d;
      m_user_q <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.access) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    m_data_d = '0;
    if (rd_ok_q) begin
      m_data_d[deq_pkg::ValueW-1:0] = rd_q.value;
      m_data_d[deq_pkg::ValueW]     = rd_q.tag;
    end
    m_data_d[deq_pkg::ValueW+1 +: CW] = count_q;

    if (cmd_i.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  assign stat_o.out_busy = m_valid_q;
  assign m_valid_o       = m_valid_q;
  assign m_data_o        = m_data_q;
  assign m_user_o        = m_user_q;

endmodule

>>> hdl/double_ended_queue_core.sv
// Top level of the double-ended queue core: controller plus datapath.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
//
//   channel  dir  tdata (low bit up)                     tuser
//   s_axis   in   value_in[31:0], tag_in, zero pad       func[2:0]
//   m_axis   out  value_out[31:0], tag_out, occupancy,   status[1:0]
//                 zero pad
//
// Each request passes through accept, one ring memory access (single
// port, registered read), then loading of the output register.
// A result waiting in the output register does not stop the next request
// from being accepted; only its final load waits for m_axis_tready.
// Reset clears head, count and output valid; the entry memory needs no clear.
module double_ended_queue_core #(
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned CW    = $clog2(DEPTH + 1),
  localparam int unsigned OUT_W = ((deq_pkg::ValueW + 1 + CW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [deq_pkg::InDataW-1:0]  s_axis_tdata,  // value_in, tag_in
  input  logic [deq_pkg::FuncW-1:0]    s_axis_tuser,  // func
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OUT_W-1:0]             m_axis_tdata,  // value_out, tag_out, occupancy
  output logic [deq_pkg::StatW-1:0]    m_axis_tuser   // status
);

  deq_pkg::deq_cmd_t  cmd;
  deq_pkg::deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .func_i    (s_axis_tuser),
    .value_i   (s_axis_tdata[deq_pkg::ValueW-1:0]),
    .tag_i     (s_axis_tdata[deq_pkg::ValueW]),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser)
  );

  a_access_follows_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.access |-> $past(cmd.latch_in)
  ) else $error("ring access without an accepted beat");

  a_one_in_flight: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.latch_in |=> !s_axis_tready
  ) else $error("second beat accepted while a request is in progress");

  a_no_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      cmd.load_out |-> (!m_axis_tvalid || m_axis_tready)
  ) else $error("pending result overwritten");

  a_occupancy_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tdata[deq_pkg::ValueW+1 +: CW] <= CW'(DEPTH))
  ) else $error("occupancy above depth");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for double_ended_queue_core: directed and random deque requests with
// random idling on both streams, each result checked against a ring model.
// Depends on deq_pkg and the double_ended_queue_core RTL.
module testbench;
  import deq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W        = $clog2(DEPTH);
  localparam int unsigned OUT_W        = ((ValueW + 1 + CNT_W + 7) / 8) * 8;
  localparam int          RANDOM_ITEMS = 950;
  localparam int          SINK_HOLD    = 120;
  localparam int          IDLE_LIMIT   = 1500;
  localparam int          TAIL_CYCLES  = 8;

  localparam logic [FuncW-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FuncW-1:0] FUNC_SPARE_HI = 3'd7;

  typedef struct {
    logic [ValueW-1:0] value;
    logic              tag;
    logic [CNT_W-1:0]  occupancy;
    logic [StatW-1:0]  status;
  } deque_result_t;

  class deque_tracker;
    logic [ValueW-1:0] ring_value [DEPTH];
    logic              ring_tag   [DEPTH];
    logic [IDX_W-1:0]  front_idx;
    logic [CNT_W-1:0]  held;
    deque_result_t     results_due [$];
    int                mismatches;

    function new();
      front_idx  = '0;
      held       = '0;
      mismatches = 0;
    endfunction

    function void note_request(logic [FuncW-1:0] op, logic [ValueW-1:0] value, logic tag);
      deque_result_t    r;
      logic [IDX_W-1:0] pos;
      r.value  = '0;
      r.tag    = 1'b0;
      r.status = STAT_OK;
      case (op) inside
        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
          if (held == DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            if (op == FUNC_PUSH_FRONT) begin
              front_idx = front_idx - 1'b1;
              pos       = front_idx;
            end else begin
              pos = front_idx + held[IDX_W-1:0];
            end
            ring_value[pos] = value;
            ring_tag[pos]   = tag;
            held++;
          end
        end
        FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_PEEK_FRONT, FUNC_PEEK_BACK: begin
          if (held == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            if (op == FUNC_POP_FRONT || op == FUNC_PEEK_FRONT) pos = front_idx;
            else pos = front_idx + held[IDX_W-1:0] - 1'b1;
            r.value = ring_value[pos];
            r.tag   = ring_tag[pos];
            if (op == FUNC_POP_FRONT) begin
              front_idx = front_idx + 1'b1;
              held--;
            end else if (op == FUNC_POP_BACK) begin
              held--;
            end
          end
        end
        default: ;
      endcase
      r.occupancy = held;
      results_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic [StatW-1:0] user);
      deque_result_t r;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got data %h status %0d",
                 $time, data, user);
        mismatches++;
        return;
      end
      r = results_due.pop_front();
      compare_field("value_out", r.value, data[ValueW-1:0]);
      compare_field("tag_out", 32'(r.tag), 32'(data[ValueW]));
      compare_field("occupancy", 32'(r.occupancy), 32'(data[ValueW+CNT_W:ValueW+1]));
      compare_field("status", 32'(r.status), 32'(user));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;  // value_in[31:0], tag_in, zero pad
  logic [FuncW-1:0]     s_axis_tuser;  // func[2:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;  // value_out[31:0], tag_out, occupancy[4:0], zero pad
  logic [StatW-1:0]     m_axis_tuser;  // status[1:0]

  deque_tracker sb;
  bit           steady;
  int           hold_requests;
  int           holds_done;
  int           idle_cycles = 0;

  double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [FuncW-1:0] op, input logic [ValueW-1:0] value,
                              input logic tag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - ValueW - 1){1'b0}}, tag, value};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.results_due.size() != 0) @(posedge clk_i);
  endtask

  // Log accepted beats on both streams.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tuser, s_axis_tdata[ValueW-1:0], s_axis_tdata[ValueW]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("[double_ended_queue_core] ERROR");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold when requested.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    holds_done = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_done != hold_requests) begin
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk_i);
        holds_done++;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    int               sent;
    int               seg;
    int               seg_len;
    int               push_pct;
    logic [FuncW-1:0] op;
    sb            = new();
    steady        = 1'b0;
    hold_requests = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, extremes at both ends, fill to full, spare selectors, drain.
    send_request(FUNC_POP_FRONT, $urandom, 1'b1);
    send_request(FUNC_POP_BACK, $urandom, 1'b0);
    send_request(FUNC_PEEK_FRONT, $urandom, 1'b1);
    send_request(FUNC_PEEK_BACK, $urandom, 1'b0);
    send_request(FUNC_PUSH_FRONT, 32'h8000_0000, 1'b0);
    send_request(FUNC_PUSH_BACK, 32'h7FFF_FFFF, 1'b1);
    send_request(FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1);
    send_request(FUNC_PUSH_BACK, 32'h0000_0000, 1'b0);
    for (int i = 0; i < DEPTH - 4; i++)
      send_request((i % 2) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, pick_value(), i[0]);
    send_request(FUNC_PUSH_FRONT, $urandom, 1'b1);
    send_request(FUNC_PUSH_BACK, $urandom, 1'b0);
    send_request(FUNC_SPARE_LO, $urandom, 1'b1);
    send_request(FUNC_SPARE_HI, $urandom, 1'b0);
    send_request(FUNC_PEEK_FRONT, $urandom, 1'b0);
    send_request(FUNC_PEEK_BACK, $urandom, 1'b1);
    send_request(FUNC_POP_FRONT, $urandom, 1'b0);
    send_request(FUNC_POP_BACK, $urandom, 1'b1);
    wait_drained();

    sent = 0;
    seg  = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 75;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      steady = ($urandom_range(0, 4) == 0);
      if (seg == 4) begin
        // Hold the receiver off while offering back to back.
        hold_requests++;
        steady   = 1'b1;
        push_pct = 60;
      end
      if (seg == 9) wait_drained();
      for (int j = 0; j < seg_len && sent < RANDOM_ITEMS; j++) begin
        if ($urandom_range(0, 99) < 3)
          op = FuncW'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        else if ($urandom_range(0, 99) < push_pct)
          op = FuncW'($urandom_range(FUNC_PUSH_FRONT, FUNC_PUSH_BACK));
        else op = FuncW'($urandom_range(FUNC_POP_FRONT, FUNC_PEEK_BACK));
        send_request(op, pick_value(), 1'($urandom_range(0, 1)));
        sent++;
      end
      seg++;
    end
    steady = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("[double_ended_queue_core] OK");
    end else begin
      $display("[double_ended_queue_core] ERROR");
    end
    $finish;
  end

endmodule

>>> double_ended_queue_core.f
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_datapath.sv
hdl/double_ended_queue_core.sv
tb/sv/testbench.sv
